[rtl/core/ssp_pkg.sv]
package ssp_pkg;

	localparam int NODE_BITS = 7;
	localparam int CFG_INDEX_BITS = 2;

	localparam int MAX_NODES_DEFAULT = 64;
	localparam int MAX_EDGES_DEFAULT = 1024;
	localparam int WEIGHT_BITS_DEFAULT = 32;
	localparam int DIST_BITS_DEFAULT = 48;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_COUNT = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_NODE = 2'd1;

	localparam logic [NODE_BITS-1:0] NODE_COUNT_RESET = 7'd64;
	localparam logic [NODE_BITS-1:0] SOURCE_NODE_RESET = 7'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_R_FETCH,
		ST_R_READ,
		ST_R_EVAL,
		ST_CHECK,
		ST_C_FETCH,
		ST_C_READ,
		ST_C_EVAL,
		ST_N_READ,
		ST_N_LOAD,
		ST_EMIT
	} ssp_state_t;

	typedef struct packed {
		logic load;
		logic init;
		logic round_start;
		logic check_start;
		logic sample;
		logic node_mode;
		logic relax_write;
		logic edge_next;
		logic node_next;
		logic out_cycle;
		logic out_node;
		logic finish;
	} ssp_cmd_t;

	typedef struct packed {
		logic start;
		logic few_nodes;
		logic edge_empty;
		logic edge_last;
		logic relax;
		logic changed;
		logic rounds_done;
		logic out_last;
	} ssp_status_t;

endpackage

[rtl/core/ssp_ctrl.sv]
module ssp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ssp_pkg::ssp_status_t  st,
	input  logic                  out_stall,
	output ssp_pkg::ssp_cmd_t     cmd,
	output logic                  in_stall,
	output logic                  out_valid
);

	ssp_pkg::ssp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ssp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = 1'b1;
				if (st.start) begin
					state_d = ssp_pkg::ST_INIT;
				end
			end
			ssp_pkg::ST_INIT: begin
				cmd.init = 1'b1;
				state_d = st.few_nodes ? ssp_pkg::ST_CHECK : ssp_pkg::ST_ROUND;
			end
			ssp_pkg::ST_ROUND: begin
				cmd.round_start = 1'b1;
				// an empty edge list changes nothing: go straight to the check
				state_d = st.edge_empty ? ssp_pkg::ST_CHECK : ssp_pkg::ST_R_FETCH;
			end
			ssp_pkg::ST_R_FETCH: begin
				state_d = ssp_pkg::ST_R_READ;
			end
			ssp_pkg::ST_R_READ: begin
				cmd.sample = 1'b1;
				state_d = ssp_pkg::ST_R_EVAL;
			end
			ssp_pkg::ST_R_EVAL: begin
				cmd.relax_write = 1'b1;
				cmd.edge_next = 1'b1;
				if (!st.edge_last) begin
					state_d = ssp_pkg::ST_R_FETCH;
				end else if (!st.changed || st.rounds_done) begin
					state_d = ssp_pkg::ST_CHECK;
				end else begin
					state_d = ssp_pkg::ST_ROUND;
				end
			end
			ssp_pkg::ST_CHECK: begin
				cmd.check_start = 1'b1;
				state_d = st.edge_empty ? ssp_pkg::ST_N_READ : ssp_pkg::ST_C_FETCH;
			end
			ssp_pkg::ST_C_FETCH: begin
				state_d = ssp_pkg::ST_C_READ;
			end
			ssp_pkg::ST_C_READ: begin
				cmd.sample = 1'b1;
				state_d = ssp_pkg::ST_C_EVAL;
			end
			ssp_pkg::ST_C_EVAL: begin
				cmd.edge_next = 1'b1;
				if (st.relax) begin
					cmd.out_cycle = 1'b1;
					state_d = ssp_pkg::ST_EMIT;
				end else if (st.edge_last) begin
					state_d = ssp_pkg::ST_N_READ;
				end else begin
					state_d = ssp_pkg::ST_C_FETCH;
				end
			end
			ssp_pkg::ST_N_READ: begin
				cmd.sample = 1'b1;
				cmd.node_mode = 1'b1;
				state_d = ssp_pkg::ST_N_LOAD;
			end
			ssp_pkg::ST_N_LOAD: begin
				cmd.out_node = 1'b1;
				state_d = ssp_pkg::ST_EMIT;
			end
			ssp_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (st.out_last) begin
						cmd.finish = 1'b1;
						state_d = ssp_pkg::ST_IDLE;
					end else begin
						cmd.node_next = 1'b1;
						state_d = ssp_pkg::ST_N_READ;
					end
				end
			end
			default: begin
				state_d = ssp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/ssp_datapath.sv]
module ssp_datapath #(
	parameter int MAX_NODES = ssp_pkg::MAX_NODES_DEFAULT,
	parameter int MAX_EDGES = ssp_pkg::MAX_EDGES_DEFAULT,
	parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEFAULT,
	parameter int DIST_BITS = ssp_pkg::DIST_BITS_DEFAULT
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ssp_pkg::ssp_cmd_t                      cmd,
	output ssp_pkg::ssp_status_t                   st,
	input  logic                                   cfg_valid,
	input  logic [ssp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [ssp_pkg::NODE_BITS-1:0]          cfg_data,
	input  logic                                   in_valid,
	input  logic [ssp_pkg::NODE_BITS-1:0]          from_node,
	input  logic [ssp_pkg::NODE_BITS-1:0]          to_node,
	input  logic signed [WEIGHT_BITS-1:0]          weight,
	input  logic                                   last_edge,
	output logic [ssp_pkg::NODE_BITS-1:0]          node_index,
	output logic signed [DIST_BITS-1:0]            distance,
	output logic                                   reachable,
	output logic                                   negative_cycle,
	output logic                                   last
);

	localparam int NB = ssp_pkg::NODE_BITS;
	localparam int AW = $clog2(MAX_NODES);
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ETW = $clog2(MAX_EDGES + 1);
	localparam int EDGE_WIDTH = 2 * NB + WEIGHT_BITS;

	logic [NB-1:0] node_count_q, source_node_q, n_eff;
	logic [ETW-1:0] edge_total_q;
	logic [EW-1:0] edge_idx_q;
	logic [NB-1:0] round_q, node_q;
	logic changed_q;
	logic [MAX_NODES-1:0] flags_q;

	logic [EDGE_WIDTH-1:0] edge_mem [MAX_EDGES];
	logic [EDGE_WIDTH-1:0] edge_rd_q;
	logic [DIST_BITS-1:0] dist_mem [MAX_NODES];
	logic signed [DIST_BITS-1:0] dist_a_q, dist_b_q;

	logic [NB-1:0] rd_from, rd_to, a_node, v_s1;
	logic signed [WEIGHT_BITS-1:0] w_s1;
	logic range_s1, fu_s1, fv_s1;
	logic [AW-1:0] addr_a, addr_b, src_addr, v_addr;
	logic src_ok, edge_we, relax, dist_we;
	logic signed [DIST_BITS-1:0] d_sum, dist_wd;
	logic [AW-1:0] dist_wa;

	// effective vertex count: zero acts as one, clamp to the store depth
	always_comb begin
		if (node_count_q == '0) begin
			n_eff = NB'(1);
		end else if (int'(node_count_q) > MAX_NODES) begin
			n_eff = NB'(MAX_NODES);
		end else begin
			n_eff = node_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= ssp_pkg::NODE_COUNT_RESET;
			source_node_q <= ssp_pkg::SOURCE_NODE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == ssp_pkg::CFG_NODE_COUNT) begin
				node_count_q <= cfg_data;
			end else if (cfg_index == ssp_pkg::CFG_SOURCE_NODE) begin
				source_node_q <= cfg_data;
			end
		end
	end

	assign edge_we = cmd.load && in_valid && (edge_total_q < ETW'(MAX_EDGES));

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_total_q[EW-1:0]] <= {from_node, to_node, weight};
		end
		edge_rd_q <= edge_mem[edge_idx_q];
	end

	assign rd_from = edge_rd_q[EDGE_WIDTH-1 -: NB];
	assign rd_to = edge_rd_q[EDGE_WIDTH-NB-1 -: NB];
	assign a_node = cmd.node_mode ? node_q : rd_from;
	assign addr_a = AW'(a_node - NB'(1));
	assign addr_b = AW'(rd_to - NB'(1));
	assign src_addr = AW'(source_node_q - NB'(1));
	assign v_addr = AW'(v_s1 - NB'(1));
	assign src_ok = (source_node_q != '0) && (source_node_q <= n_eff);

	always_ff @(posedge clk) begin
		if (cmd.sample) begin
			v_s1 <= rd_to;
			w_s1 <= edge_rd_q[WEIGHT_BITS-1:0];
			range_s1 <= (rd_from != '0) && (rd_from <= n_eff)
				&& (rd_to != '0) && (rd_to <= n_eff);
			fu_s1 <= flags_q[addr_a];
			fv_s1 <= flags_q[addr_b];
		end
	end

	assign d_sum = dist_a_q + DIST_BITS'(w_s1);
	assign relax = range_s1 && fu_s1 && (!fv_s1 || (d_sum < dist_b_q));

	assign dist_we = (cmd.init && src_ok) || (cmd.relax_write && relax);
	assign dist_wa = cmd.init ? src_addr : v_addr;
	assign dist_wd = cmd.init ? '0 : d_sum;

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		dist_a_q <= dist_mem[addr_a];
		dist_b_q <= dist_mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			edge_total_q <= '0;
			edge_idx_q <= '0;
			round_q <= '0;
			changed_q <= 1'b0;
			node_q <= '0;
		end else begin
			if (cmd.init) begin
				if (src_ok) begin
					flags_q <= MAX_NODES'(1) << src_addr;
				end else begin
					flags_q <= '0;
				end
				round_q <= '0;
				changed_q <= 1'b0;
			end else if (cmd.relax_write && relax) begin
				flags_q[v_addr] <= 1'b1;
				changed_q <= 1'b1;
			end
			if (cmd.round_start) begin
				round_q <= round_q + NB'(1);
				changed_q <= 1'b0;
			end
			if (edge_we) begin
				edge_total_q <= edge_total_q + ETW'(1);
			end else if (cmd.finish) begin
				edge_total_q <= '0;
			end
			if (cmd.round_start || cmd.check_start) begin
				edge_idx_q <= '0;
			end else if (cmd.edge_next) begin
				edge_idx_q <= edge_idx_q + EW'(1);
			end
			if (cmd.check_start) begin
				node_q <= NB'(1);
			end else if (cmd.node_next) begin
				node_q <= node_q + NB'(1);
			end
		end
	end

	// result register, held until the beat is taken
	always_ff @(posedge clk) begin
		if (cmd.out_cycle) begin
			node_index <= '0;
			distance <= '0;
			reachable <= 1'b0;
			negative_cycle <= 1'b1;
			last <= 1'b1;
		end else if (cmd.out_node) begin
			node_index <= node_q;
			distance <= fu_s1 ? dist_a_q : '0;
			reachable <= fu_s1;
			negative_cycle <= 1'b0;
			last <= (node_q == n_eff);
		end
	end

	always_comb begin
		st.start = cmd.load && in_valid && last_edge;
		st.few_nodes = (n_eff <= NB'(1));
		st.edge_empty = (edge_total_q == '0);
		st.edge_last = ((ETW'(edge_idx_q) + ETW'(1)) == edge_total_q);
		st.relax = relax;
		st.changed = changed_q || relax;
		st.rounds_done = (round_q >= (n_eff - NB'(1)));
		st.out_last = last;
	end

endmodule

[rtl/core/single_source_shortest_path.sv]
// Single-source shortest paths (Bellman-Ford). Edges are loaded one beat per
// cycle into an edge memory; the beat with last_edge set is stored too and
// starts the run, during which in_stall stays high. A setup step follows the
// final edge. Each relaxation round and the final negative-cycle pass take
// three steps per stored edge (edge memory read, distance memory read, add and
// compare, with write-back only in the rounds), after a start step each; at
// most node_count-1 rounds run, fewer when a round changes nothing, and the
// pass stops at the first edge that still relaxes. Each vertex beat is read,
// loaded and held while out_stall is high; the next is prepared only once it
// is taken. Results are either one flagged negative-cycle beat or one beat per
// vertex 1..node_count (clamped to MAX_NODES, zero taken as one). The edge
// list is emptied after the final beat. No clearing pass follows reset.
module single_source_shortest_path #(
	parameter int MAX_NODES = ssp_pkg::MAX_NODES_DEFAULT,
	parameter int MAX_EDGES = ssp_pkg::MAX_EDGES_DEFAULT,
	parameter int WEIGHT_BITS = ssp_pkg::WEIGHT_BITS_DEFAULT,
	parameter int DIST_BITS = ssp_pkg::DIST_BITS_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [ssp_pkg::NODE_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ssp_pkg::NODE_BITS-1:0]       from_node,
	input  logic [ssp_pkg::NODE_BITS-1:0]       to_node,
	input  logic signed [WEIGHT_BITS-1:0]       weight,
	input  logic                                last_edge,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ssp_pkg::NODE_BITS-1:0]       node_index,
	output logic signed [DIST_BITS-1:0]         distance,
	output logic                                reachable,
	output logic                                negative_cycle,
	output logic                                last
);

	ssp_pkg::ssp_cmd_t cmd;
	ssp_pkg::ssp_status_t st;

	assign cfg_ready = 1'b1;

	ssp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.st        (st),
		.out_stall (out_stall),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	ssp_datapath #(
		.MAX_NODES   (MAX_NODES),
		.MAX_EDGES   (MAX_EDGES),
		.WEIGHT_BITS (WEIGHT_BITS),
		.DIST_BITS   (DIST_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.from_node      (from_node),
		.to_node        (to_node),
		.weight         (weight),
		.last_edge      (last_edge),
		.node_index     (node_index),
		.distance       (distance),
		.reachable      (reachable),
		.negative_cycle (negative_cycle),
		.last           (last)
	);

endmodule
